>>> rtl/core/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg: shared constants and helpers for the integer to radix text block
// Character codes, radix limits and the digit to character mapping.
// ----------------------------------------------------------------------------
package itra_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int RADIX_W       = 6;
  localparam int CHAR_W        = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_MAX = 6'd9;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  // digit value to lower-case ascii
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d > DIGIT_MAX) begin
      r = {2'b00, d} - {2'b00, RADIX_DEC} + CHAR_A;
    end else begin
      r = {2'b00, d} + CHAR_ZERO;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/int_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// int_to_radix_ascii: signed integer to ascii text in radix 2 to 36
// Emits the text most significant character first, flagging the final one.
// ----------------------------------------------------------------------------
// usage:
//   slave stream: tdata holds value (WordBits bits, signed) then radix (6 bits),
//   zero padded to whole bytes. radix outside 2..36 is clamped. in radix 10 a
//   negative value is printed as '-' and its magnitude; in other radices the
//   two's complement pattern is printed unsigned.
//   master stream: tdata is one ascii character per item, tlast on the final
//   character of the number.
// flow:
//   each digit is the remainder of one pass of the bit-serial divider and
//   is stored at the end of that pass; each character is then read out
//   through the registered read of the digit memory, a sign first from its
//   own state. the engine takes no new item until the last character of the
//   current one is in the output register. items pass the registered queue
//   before the engine; a two-entry queue behind the input lets items be
//   taken while the engine is busy or a result waits.
// reset: clears the queue, the engine state and the output valid.
// stall: a low m_axis_tready_i holds the current character and pauses the
//   engine before the next character; nothing is dropped.
// ----------------------------------------------------------------------------
module int_to_radix_ascii #(
  parameter int WORD_BITS = itra_pkg::WORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // [WORD_BITS-1:0] value, [WORD_BITS+5:WORD_BITS] radix, rest zero
  input  logic [((WORD_BITS + itra_pkg::RADIX_W + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // [7:0] character
  output logic [itra_pkg::CHAR_W-1:0] m_axis_tdata_o,
  output logic m_axis_tlast_o
);
  import itra_pkg::*;

  localparam int EntryW = WORD_BITS + RADIX_W + 1;

  logic                 f_valid, f_ready, f_neg;
  logic [WORD_BITS-1:0] f_pattern;
  logic [RADIX_W-1:0]   f_radix;
  logic                 q_valid, q_ready;
  logic [EntryW-1:0]    q_data;

  itra_front #(
    .WordBits (WORD_BITS)
  ) u_front (
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .value_i    (s_axis_tdata_i[WORD_BITS-1:0]),
    .radix_i    (s_axis_tdata_i[WORD_BITS+RADIX_W-1:WORD_BITS]),
    .q_valid_o  (f_valid),
    .q_ready_i  (f_ready),
    .pattern_o  (f_pattern),
    .radix_o    (f_radix),
    .negative_o (f_neg)
  );

  itra_fifo #(
    .Width (EntryW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_neg, f_radix, f_pattern}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  itra_conv #(
    .WordBits (WORD_BITS)
  ) u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .pattern_i  (q_data[WORD_BITS-1:0]),
    .radix_i    (q_data[WORD_BITS+RADIX_W-1:WORD_BITS]),
    .negative_i (q_data[EntryW-1]),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .char_o     (m_axis_tdata_o),
    .last_o     (m_axis_tlast_o)
  );

endmodule

>>> rtl/core/itra_front.sv
// ----------------------------------------------------------------------------
// itra_front: input classification
// Saturates the radix and turns a negative decimal value into its magnitude.
// ----------------------------------------------------------------------------
module itra_front #(
  parameter int WordBits = itra_pkg::WORD_BITS_DEF
) (
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [WordBits-1:0]          value_i,
  input  logic [itra_pkg::RADIX_W-1:0] radix_i,
  output logic                         q_valid_o,
  input  logic                         q_ready_i,
  output logic [WordBits-1:0]          pattern_o,
  output logic [itra_pkg::RADIX_W-1:0] radix_o,
  output logic                         negative_o
);
  import itra_pkg::*;

  logic [RADIX_W-1:0] radix_sat;

  always_comb begin
    priority if (radix_i < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = radix_i;
    end
  end

  // only decimal text carries a sign
  assign negative_o = (radix_sat == RADIX_DEC) && value_i[WordBits-1];
  assign pattern_o  = negative_o ? (~value_i + WordBits'(1)) : value_i;
  assign radix_o    = radix_sat;
  assign q_valid_o  = s_valid_i;
  assign s_ready_o  = q_ready_i;

endmodule

>>> rtl/core/itra_fifo.sv
// ----------------------------------------------------------------------------
// itra_fifo: two-entry queue
// Holds classified items between the front and the conversion engine.
// ----------------------------------------------------------------------------
module itra_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

>>> rtl/core/itra_conv.sv
// ----------------------------------------------------------------------------
// itra_conv: digit engine and character output
// Bit-serial division by the radix, digit memory, and msb-first emission.
// ----------------------------------------------------------------------------
module itra_conv #(
  parameter int WordBits = itra_pkg::WORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  logic [WordBits-1:0]          pattern_i,
  input  logic [itra_pkg::RADIX_W-1:0] radix_i,
  input  logic                         negative_i,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output logic [itra_pkg::CHAR_W-1:0]  char_o,
  output logic                         last_o
);
  import itra_pkg::*;

  localparam int Depth = WordBits + 1;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);
  localparam int BW    = $clog2(WordBits);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_READ = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [WordBits-1:0] div_q, div_d;
  logic [RADIX_W-1:0]  rem_q, rem_d;
  logic [BW-1:0]       bcnt_q, bcnt_d;
  logic [RADIX_W-1:0]  radix_q, radix_d;
  logic                neg_q, neg_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   out_char_q, out_char_d;
  logic                out_last_q, out_last_d;

  logic [CHAR_W-1:0]   store_q [Depth];
  logic [CHAR_W-1:0]   rd_data_q;
  logic                we, re;
  logic [AW-1:0]       waddr;
  logic [CHAR_W-1:0]   wdata;

  logic [RADIX_W:0]    r2, diff;
  logic                ge;
  logic [RADIX_W-1:0]  rem_n;
  logic [WordBits-1:0] div_n;
  logic                out_free;

  // one restoring division step per cycle
  assign r2    = {rem_q, div_q[WordBits-1]};
  assign ge    = (r2 >= {1'b0, radix_q});
  assign diff  = r2 - {1'b0, radix_q};
  assign rem_n = ge ? diff[RADIX_W-1:0] : r2[RADIX_W-1:0];
  assign div_n = {div_q[WordBits-2:0], ge};

  assign out_free  = !out_valid_q || m_ready_i;
  assign q_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;
  assign char_o    = out_char_q;
  assign last_o    = out_last_q;

  always_comb begin
    state_d     = state_q;
    div_d       = div_q;
    rem_d       = rem_q;
    bcnt_d      = bcnt_q;
    radix_d     = radix_q;
    neg_d       = neg_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = count_q[AW-1:0];
    wdata       = digit_char(rem_n);

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          div_d   = pattern_i;
          rem_d   = '0;
          bcnt_d  = BW'(WordBits - 1);
          radix_d = radix_i;
          neg_d   = negative_i;
          count_d = '0;
          if (pattern_i == '0) begin
            we      = 1'b1;
            waddr   = '0;
            wdata   = CHAR_ZERO;
            count_d = CW'(1);
            idx_d   = '0;
            state_d = ST_READ;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        div_d  = div_n;
        rem_d  = rem_n;
        bcnt_d = bcnt_q - BW'(1);
        if (bcnt_q == '0) begin
          // remainder is the next digit, quotient feeds the next pass
          we      = 1'b1;
          count_d = count_q + CW'(1);
          idx_d   = count_q[AW-1:0];
          rem_d   = '0;
          bcnt_d  = BW'(WordBits - 1);
          if (div_n == '0 || count_d == CW'(Depth)) begin
            state_d = neg_q ? ST_SIGN : ST_READ;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        re      = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = rd_data_q;
          out_last_d  = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_q       <= '0;
      rem_q       <= '0;
      bcnt_q      <= '0;
      radix_q     <= RADIX_MIN;
      neg_q       <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_q       <= div_d;
      rem_q       <= rem_d;
      bcnt_q      <= bcnt_d;
      radix_q     <= radix_d;
      neg_q       <= neg_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // digit memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) store_q[waddr] <= wdata;
    if (re) rd_data_q <= store_q[idx_q];
  end

endmodule
